FILE: design/slc_pkg.sv
// ----------------------------------------------------------------------------
// slc_pkg: shared definitions for the sorted list engine
// Field widths, command and status codes, and the per-cycle cell operation.
// ----------------------------------------------------------------------------
package slc_pkg;

  localparam int DEPTH_DEFAULT = 16;

  localparam int CMD_W    = 2;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int TOTAL_W  = 5;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LIST   = 2'd2;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd3;

  // Operation broadcast to every cell of the chain
  typedef struct packed {
    logic ins;  // insert the item value at the first entry not below it
    logic del;  // remove the first entry equal to the item value
    logic rot;  // rotate the occupied part one place toward cell 0
  } slc_op_t;

endpackage

FILE: design/slc_if.sv
// ----------------------------------------------------------------------------
// slc_if: handshake channels of the sorted list engine
// Command channel (cmd, item_value) and result channel with valid/ready.
// ----------------------------------------------------------------------------
interface slc_item_if;
  import slc_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [CMD_W-1:0]          cmd;
  logic signed [VALUE_W-1:0] item_value;

  modport source (output valid, output cmd, output item_value, input ready);
  modport sink   (input valid, input cmd, input item_value, output ready);
endinterface

interface slc_result_if;
  import slc_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] out_value;
  logic [STATUS_W-1:0]       status;
  logic [TOTAL_W-1:0]        entry_total;
  logic                      last_result;

  modport source (output valid, output out_value, output status,
                  output entry_total, output last_result, input ready);
  modport sink   (input valid, input out_value, input status,
                  input entry_total, input last_result, output ready);
endinterface

FILE: design/slc_cell.sv
// ----------------------------------------------------------------------------
// slc_cell: one storage cell of the sorted chain
// Holds one entry, compares it against the item value and takes its next
// value from itself, the item, or a neighbor.
// ----------------------------------------------------------------------------
module slc_cell (
  input  logic                              clk,
  input  slc_pkg::slc_op_t                  op,
  input  logic signed [slc_pkg::VALUE_W-1:0] x,
  input  logic signed [slc_pkg::VALUE_W-1:0] left_val,
  input  logic signed [slc_pkg::VALUE_W-1:0] right_val,
  input  logic signed [slc_pkg::VALUE_W-1:0] head_val,
  input  logic                              left_ge,
  input  logic                              occupied,
  input  logic                              is_tail,
  output logic signed [slc_pkg::VALUE_W-1:0] val,
  output logic                              ge,
  output logic                              eq
);
  import slc_pkg::*;

  logic signed [VALUE_W-1:0] val_next;

  // Empty cells count as "not below" so the mark is monotone along the chain
  assign ge = !occupied || (val >= x);
  assign eq = occupied && (val == x);

  // Next value: shift right on insert, shift left on delete or rotate
  always_comb begin
    val_next = val;
    if (op.ins) begin
      if (left_ge) val_next = left_val;
      else if (ge) val_next = x;
    end else if (op.del) begin
      if (ge) val_next = right_val;
    end else if (op.rot) begin
      val_next = is_tail ? head_val : right_val;
    end
  end

  always_ff @(posedge clk) begin
    val <= val_next;
  end

endmodule

FILE: design/sorted_list_engine.sv
// ----------------------------------------------------------------------------
// sorted_list_engine: ascending list of signed values in a chain of cells
// Insert and delete finish in the cycle of the accepted beat; their result
// is valid on the next cycle; a new command is taken every cycle while the
// output stage can load and no list runs. A list of N entries is set up on
// acceptance, then gives one result per cycle while results are taken, as
// the chain rotates through cell 0; an empty list gives one result. Reset
// clears entry count and result valid; cells stay undefined until written.
// ----------------------------------------------------------------------------
module sorted_list_engine #(
  parameter int DEPTH = slc_pkg::DEPTH_DEFAULT
) (
  input logic          clk,
  input logic          rst,
  slc_item_if.sink     item,
  slc_result_if.source result
);
  import slc_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  logic [CW-1:0]             count;
  logic [CW-1:0]             remain;
  logic                      busy;
  logic                      out_v;
  logic signed [VALUE_W-1:0] out_value;
  logic [STATUS_W-1:0]       status;
  logic [TOTAL_W-1:0]        entry_total;
  logic                      last_result;

  logic signed [VALUE_W-1:0] cell_val [DEPTH];
  logic [DEPTH-1:0]          cell_ge;
  logic [DEPTH-1:0]          cell_eq;
  logic                      can_load;
  logic                      acc;
  logic                      step;
  logic                      found;
  logic                      full;
  logic                      emit_beat;
  slc_op_t                   op;

  // Handshake and broadcast operation
  assign can_load   = !out_v || result.ready;
  assign item.ready = !busy && can_load;
  assign acc        = item.valid && item.ready;
  assign step       = busy && can_load;
  assign found      = |cell_eq;
  assign full       = (count == CW'(DEPTH));

  assign op.ins = acc && (item.cmd == CMD_INSERT) && !full;
  assign op.del = acc && (item.cmd == CMD_DELETE) && found;
  assign op.rot = step;

  // A result beat is loaded on every insert, delete, empty list and list step
  assign emit_beat = step ||
                     (acc && ((item.cmd == CMD_INSERT) || (item.cmd == CMD_DELETE) ||
                              ((item.cmd == CMD_LIST) && (count == '0))));

  // Chain of cells
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [VALUE_W-1:0] lv;
    logic signed [VALUE_W-1:0] rv;
    logic                      lg;

    if (i == 0) begin : g_head
      assign lv = item.item_value;
      assign lg = 1'b0;
    end else begin : g_mid
      assign lv = cell_val[i-1];
      assign lg = cell_ge[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign rv = cell_val[i];
    end else begin : g_body
      assign rv = cell_val[i+1];
    end

    slc_cell u_cell (
      .clk       (clk),
      .op        (op),
      .x         (item.item_value),
      .left_val  (lv),
      .right_val (rv),
      .head_val  (cell_val[0]),
      .left_ge   (lg),
      .occupied  (CW'(i) < count),
      .is_tail   (CW'(i) == count - CW'(1)),
      .val       (cell_val[i]),
      .ge        (cell_ge[i]),
      .eq        (cell_eq[i])
    );
  end

  // Count, list sequencing and output stage
  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      remain <= '0;
      busy   <= 1'b0;
      out_v  <= 1'b0;
    end else begin
      if (emit_beat) out_v <= 1'b1;
      else if (result.ready) out_v <= 1'b0;

      if (acc) begin
        unique case (item.cmd)
          CMD_INSERT: begin
            out_value   <= item.item_value;
            last_result <= 1'b1;
            if (full) begin
              status      <= ST_FULL;
              entry_total <= TOTAL_W'(count);
            end else begin
              status      <= ST_OK;
              entry_total <= TOTAL_W'(count + CW'(1));
              count       <= count + CW'(1);
            end
          end
          CMD_DELETE: begin
            out_value   <= item.item_value;
            last_result <= 1'b1;
            if (count == '0) begin
              status      <= ST_EMPTY;
              entry_total <= TOTAL_W'(count);
            end else if (found) begin
              status      <= ST_OK;
              entry_total <= TOTAL_W'(count - CW'(1));
              count       <= count - CW'(1);
            end else begin
              status      <= ST_NOT_FOUND;
              entry_total <= TOTAL_W'(count);
            end
          end
          CMD_LIST: begin
            if (count == '0) begin
              out_value   <= '0;
              status      <= ST_EMPTY;
              entry_total <= '0;
              last_result <= 1'b1;
            end else begin
              busy   <= 1'b1;
              remain <= count;
            end
          end
          default: ;
        endcase
      end

      // Stream one entry per beat out of cell 0
      if (step) begin
        out_value   <= cell_val[0];
        status      <= ST_OK;
        entry_total <= TOTAL_W'(count);
        last_result <= (remain == CW'(1));
        remain      <= remain - CW'(1);
        if (remain == CW'(1)) busy <= 1'b0;
      end
    end
  end

  assign result.valid       = out_v;
  assign result.out_value   = out_value;
  assign result.status      = status;
  assign result.entry_total = entry_total;
  assign result.last_result = last_result;

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("entry count above capacity");

  a_busy_nonempty: assert property (@(posedge clk) disable iff (rst)
    busy |-> (count != '0) && (remain != '0) && (remain <= count))
    else $error("list sequencer running with bad remaining count");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    op.ins |=> count == $past(count) + CW'(1))
    else $error("insert did not grow the list");

  a_delete_shrinks: assert property (@(posedge clk) disable iff (rst)
    op.del |=> count == $past(count) - CW'(1))
    else $error("delete did not shrink the list");

  a_list_holds: assert property (@(posedge clk) disable iff (rst)
    busy |=> $stable(count))
    else $error("entry count changed while listing");

endmodule

FILE: bench/sorted_list_engine_tb.sv
// ----------------------------------------------------------------------------
// sorted_list_engine_tb: self-checking bench for the sorted list engine
// Drives insert, delete, list and unused commands through the item channel.
// A shadow copy of the ordered store predicts every result beat, which is
// checked field by field at the result channel. Random gaps on both sides,
// plus one long receiver hold-off that backs the block up into its input.
// ----------------------------------------------------------------------------
module sorted_list_engine_tb;
  import slc_pkg::*;

  localparam int DEPTH = DEPTH_DEFAULT;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
  localparam int CYCLE_LIMIT = 500000;
  localparam int SETTLE_CYCLES = 2 * DEPTH + 8;
  localparam int PRINT_CAP = 50;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic [STATUS_W-1:0]       status;
    logic [TOTAL_W-1:0]        total;
    logic                      last;
  } result_beat_t;

  logic clk = 1'b0;
  logic rst;

  slc_item_if   item_ch ();
  slc_result_if result_ch ();

  sorted_list_engine #(.DEPTH(DEPTH)) DUT (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch)
  );

  // Shadow of the ordered store
  logic signed [VALUE_W-1:0] shadow_list [DEPTH];
  int                        shadow_len;

  result_beat_t expected_beats [$];
  result_beat_t head_beat;

  int fail_count  = 0;
  int cycle_count = 0;
  int hold_off    = 0;
  int stall_left  = 0;
  bit jitter      = 1'b0;

  // Clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [VALUE_W-1:0] got,
                                 input logic [VALUE_W-1:0] want);
    if (fail_count < PRINT_CAP)
      $display("MISMATCH cycle %0d: %s got %0h expected %0h", cycle_count, what, got, want);
    fail_count++;
  endtask

  // Gap length: mostly short, a few long
  function automatic int gap_len();
    if ($urandom_range(0, 99) < 80)
      return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  function automatic int sender_gap();
    if (!jitter || $urandom_range(0, 99) < 65)
      return 0;
    return gap_len();
  endfunction

  function automatic void push_beat(input logic signed [VALUE_W-1:0] v,
                                    input logic [STATUS_W-1:0] st, input logic last);
    result_beat_t b;
    b.value  = v;
    b.status = st;
    b.total  = shadow_len[TOTAL_W-1:0];
    b.last   = last;
    expected_beats.push_back(b);
  endfunction

  // Predict the result beats of one accepted command and update the shadow
  function automatic void predict_beats(input logic [CMD_W-1:0] c,
                                        input logic signed [VALUE_W-1:0] v);
    int pos;
    pos = shadow_len;
    case (c)
      CMD_INSERT: begin
        if (shadow_len >= DEPTH) begin
          push_beat(v, ST_FULL, 1'b1);
        end else begin
          // first entry not below the value; a new value goes ahead of equal ones
          for (int i = 0; i < shadow_len; i++) begin
            if (shadow_list[i] >= v) begin
              pos = i;
              break;
            end
          end
          for (int i = shadow_len; i > pos; i--)
            shadow_list[i] = shadow_list[i-1];
          shadow_list[pos] = v;
          shadow_len++;
          push_beat(v, ST_OK, 1'b1);
        end
      end
      CMD_DELETE: begin
        if (shadow_len == 0) begin
          push_beat(v, ST_EMPTY, 1'b1);
        end else begin
          for (int i = 0; i < shadow_len; i++) begin
            if (shadow_list[i] == v) begin
              pos = i;
              break;
            end
          end
          if (pos >= shadow_len) begin
            push_beat(v, ST_NOT_FOUND, 1'b1);
          end else begin
            for (int i = pos; i + 1 < shadow_len; i++)
              shadow_list[i] = shadow_list[i+1];
            shadow_len--;
            push_beat(v, ST_OK, 1'b1);
          end
        end
      end
      CMD_LIST: begin
        if (shadow_len == 0)
          push_beat('0, ST_EMPTY, 1'b1);
        else
          for (int i = 0; i < shadow_len; i++)
            push_beat(shadow_list[i], ST_OK, i + 1 == shadow_len);
      end
      default: ;  // unused command: no beat, store unchanged
    endcase
  endfunction

  // Send one command beat; valid stays high when the next one follows at once
  task automatic send_cmd(input logic [CMD_W-1:0] c, input logic signed [VALUE_W-1:0] v);
    int gap;
    gap = sender_gap();
    @(negedge clk);
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_ch.valid      <= 1'b1;
    item_ch.cmd        <= c;
    item_ch.item_value <= v;
    do @(posedge clk); while (!item_ch.ready);
    predict_beats(c, v);
  endtask

  task automatic idle_sender();
    @(negedge clk);
    item_ch.valid <= 1'b0;
  endtask

  // Random value: small range for duplicates, extremes, or any 32 bits
  function automatic logic signed [VALUE_W-1:0] draw_value();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4)
      return $signed($urandom_range(0, 16)) - 8;
    if (r == 4)
      return VAL_MIN + $urandom_range(0, 3);
    if (r == 5)
      return VAL_MAX - $urandom_range(0, 3);
    return $urandom;
  endfunction

  // Delete target: mostly a stored value
  function automatic logic signed [VALUE_W-1:0] delete_target();
    if (shadow_len > 0 && $urandom_range(0, 99) < 70)
      return shadow_list[$urandom_range(0, shadow_len - 1)];
    return draw_value();
  endfunction

  // Result sink: long hold-off on request, otherwise random stalls
  always @(negedge clk) begin
    if (hold_off > 0) begin
      result_ch.ready <= 1'b0;
      hold_off = hold_off - 1;
    end else if (stall_left > 0) begin
      result_ch.ready <= 1'b0;
      stall_left = stall_left - 1;
    end else if (jitter && $urandom_range(0, 99) < 15) begin
      result_ch.ready <= 1'b0;
      stall_left = gap_len() - 1;
    end else begin
      result_ch.ready <= 1'b1;
    end
  end

  // Result checker: compare each beat with the oldest expectation
  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (expected_beats.size() == 0) begin
        report_mismatch("beat with nothing expected, value", result_ch.out_value, '0);
      end else begin
        head_beat = expected_beats.pop_front();
        if (result_ch.out_value !== head_beat.value)
          report_mismatch("out_value", result_ch.out_value, head_beat.value);
        if (result_ch.status !== head_beat.status)
          report_mismatch("status", VALUE_W'(result_ch.status),
                          VALUE_W'(head_beat.status));
        if (result_ch.entry_total !== head_beat.total)
          report_mismatch("entry_total", VALUE_W'(result_ch.entry_total),
                          VALUE_W'(head_beat.total));
        if (result_ch.last_result !== head_beat.last)
          report_mismatch("last_result", VALUE_W'(result_ch.last_result),
                          VALUE_W'(head_beat.last));
      end
    end
  end

  // Empty store: list, delete, and the unused command
  task automatic test_empty_store();
    send_cmd(CMD_LIST, draw_value());
    send_cmd(CMD_DELETE, VAL_MIN);
    send_cmd(CMD_DELETE, VAL_MAX);
    send_cmd(CMD_UNUSED, $urandom);
    send_cmd(CMD_LIST, '0);
  endtask

  // Extreme values, duplicates, hit and miss deletes
  task automatic test_extreme_values();
    send_cmd(CMD_INSERT, VAL_MAX);
    send_cmd(CMD_INSERT, VAL_MIN);
    send_cmd(CMD_INSERT, '0);
    send_cmd(CMD_INSERT, -1);
    send_cmd(CMD_INSERT, '0);
    send_cmd(CMD_INSERT, VAL_MIN);
    send_cmd(CMD_DELETE, 32'sh1234_5678);
    send_cmd(CMD_DELETE, '0);
    send_cmd(CMD_DELETE, VAL_MAX);
    send_cmd(CMD_UNUSED, VAL_MAX);
    send_cmd(CMD_LIST, VAL_MIN);
  endtask

  // Fill to capacity, insert while full, list all, miss while full
  task automatic test_full_store();
    while (shadow_len < DEPTH)
      send_cmd(CMD_INSERT, draw_value());
    send_cmd(CMD_INSERT, VAL_MAX);
    send_cmd(CMD_LIST, '0);
    send_cmd(CMD_DELETE, 32'sh5A5A_A5A5);
  endtask

  // Receiver holds off while commands keep coming, so the block backs up
  task automatic test_backpressure();
    jitter   = 1'b0;
    hold_off = $urandom_range(200, 300);
    for (int n = 0; n < 30; n++) begin
      case (n % 4)
        0:       send_cmd(CMD_LIST, '0);
        1:       send_cmd(CMD_DELETE, delete_target());
        default: send_cmd(CMD_INSERT, draw_value());
      endcase
    end
  endtask

  // Random mix in blocks that alternate fill and drain bias and idling
  task automatic test_random_mix();
    int r;
    int ins_pct;
    int sent;
    for (int blk = 0; blk < 8; blk++) begin
      jitter  = (blk % 3) != 2;
      ins_pct = (blk % 2 == 0) ? 55 : 25;
      sent    = 0;
      while (sent < 38) begin
        r = $urandom_range(0, 99);
        if (r < 4) begin
          send_cmd(CMD_UNUSED, $urandom);
        end else begin
          r = $urandom_range(0, 99);
          if (r < ins_pct)
            send_cmd(CMD_INSERT, draw_value());
          else if (r < 85)
            send_cmd(CMD_DELETE, delete_target());
          else
            send_cmd(CMD_LIST, $urandom);
          sent++;
        end
      end
    end
  endtask

  initial begin
    rst                  = 1'b1;
    item_ch.valid        = 1'b0;
    item_ch.cmd          = CMD_INSERT;
    item_ch.item_value   = '0;
    result_ch.ready      = 1'b0;
    shadow_len           = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    jitter = 1'b1;
    test_empty_store();
    test_extreme_values();
    test_full_store();
    test_backpressure();
    test_random_mix();

    // drain, then let any stray beat show up
    idle_sender();
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (fail_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
